>>> hdl/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types, codes and defaults of the binary contour bug tracer.
// ----------------------------------------------------------------------------
package bct_pkg;

  // default image size
  localparam int DEF_IMG_WIDTH  = 64;
  localparam int DEF_IMG_HEIGHT = 64;

  // field widths
  localparam int OP_W     = 2;
  localparam int COORD_W  = 6;
  localparam int PIX_W    = 8;
  localparam int STATUS_W = 2;
  localparam int STEP_W   = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 1;

  // pixel byte that counts as foreground
  localparam logic [PIX_W-1:0] FG_BYTE = 8'd255;

  // configuration reset values
  localparam logic              MODE_RST  = 1'b0;
  localparam logic [STEP_W-1:0] LIMIT_RST = 20'd65535;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 1'd1;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_TRACE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // trace status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_LIMIT = 2'd2
  } status_e;

  // bug heading, clockwise order
  typedef enum logic [1:0] {
    HEAD_N = 2'd0,
    HEAD_E = 2'd1,
    HEAD_S = 2'd2,
    HEAD_W = 2'd3
  } head_e;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic scan_init;  // trace accepted: reset sweep and step count
    logic scan_run;   // clear one track entry, read one image entry
    logic bug_init;   // place bug at start position
    logic step_rd;    // read image under the bug
    logic step_ev;    // evaluate pixel, turn, move
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;  // sweep issues its last entry
    logic found;      // a foreground pixel was found
    logic at_start;   // step returns to start heading north
    logic at_limit;   // step count reaches the limit
  } dp_stat_t;

endpackage

>>> hdl/bct_ram.sv
// ----------------------------------------------------------------------------
// bct_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bct_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bct_ctrl.sv
// ----------------------------------------------------------------------------
// bct_ctrl
// Controller of the tracer: sequences sweep, setup and bug steps.
// ----------------------------------------------------------------------------
module bct_ctrl import bct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [OP_W-1:0]     op_i,
  input  dp_stat_t            stat_i,
  output dp_cmd_t             cmd_o,
  output logic                busy,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_TAIL,
    S_SETUP,
    S_STEP_RD,
    S_STEP_EV,
    S_FINISH
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = start;
        if (start && (op_i == OP_TRACE)) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_SETUP;
      end
      S_SETUP: begin
        if (stat_i.found) begin
          cmd_o.bug_init = 1'b1;
          state_d        = S_STEP_RD;
        end else begin
          status_d = ST_EMPTY;
          state_d  = S_FINISH;
        end
      end
      S_STEP_RD: begin
        cmd_o.step_rd = 1'b1;
        state_d       = S_STEP_EV;
      end
      S_STEP_EV: begin
        cmd_o.step_ev = 1'b1;
        if (stat_i.at_start) begin
          status_d = ST_OK;
          state_d  = S_FINISH;
        end else if (stat_i.at_limit) begin
          status_d = ST_LIMIT;
          state_d  = S_FINISH;
        end else begin
          state_d = S_STEP_RD;
        end
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = (state_q == S_FINISH);
  assign status_o = (state_q == S_FINISH) ? status_q : ST_OK;

endmodule

>>> hdl/bct_datapath.sv
// ----------------------------------------------------------------------------
// bct_datapath
// Image and track stores, sweep counters, bug position and step counter.
// ----------------------------------------------------------------------------
module bct_datapath import bct_pkg::*; #(
  parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT = DEF_IMG_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [PIX_W-1:0]     pixel_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 out_vld_o,
  output logic                 track_bit_o,
  output logic [STEP_W-1:0]    step_count_o
);

  localparam int Depth = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int RBW   = $clog2(IMG_HEIGHT);
  localparam int CUW   = $clog2(IMG_WIDTH);
  localparam int CBW   = CUW + 1;

  localparam logic [AW-1:0]  WidthA  = AW'(IMG_WIDTH);
  localparam logic [RBW-1:0] RowLast = RBW'(IMG_HEIGHT - 1);
  localparam logic [CUW-1:0] ColLast = CUW'(IMG_WIDTH - 1);
  localparam logic signed [CBW-1:0] ColLastS = CBW'(IMG_WIDTH - 1);

  // configuration registers
  logic              mode_q;
  logic [STEP_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TRACE_MODE: mode_q  <= cfg_wdata_i[0];
        CFG_STEP_LIMIT: limit_q <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // input address decode
  logic          in_inside;
  logic [AW-1:0] in_addr;

  assign in_inside = (32'(row_i) < 32'(IMG_HEIGHT)) && (32'(col_i) < 32'(IMG_WIDTH));
  assign in_addr   = AW'(AW'(row_i) * WidthA) + AW'(col_i);

  // sweep counters for clear and first-pixel search
  logic [RBW-1:0] scan_row_q, scan_row_dly_q;
  logic [CUW-1:0] scan_col_q, scan_col_dly_q;
  logic [AW-1:0]  scan_addr_q;
  logic           scan_vld_q, found_q;

  // bug state
  logic [RBW-1:0]        bug_row_q, row0_q;
  logic signed [CBW-1:0] bug_col_q, col0_q;
  head_e                 head_q;
  logic [STEP_W-1:0]     steps_q;
  logic [AW-1:0]         bug_addr_q;
  logic                  bug_in_q;
  logic                  track_ok_q;

  // store ports
  logic          img_we, img_wdata, img_rdata;
  logic [AW-1:0] img_raddr;
  logic          trk_we, trk_wdata, trk_rdata;
  logic [AW-1:0] trk_waddr;

  // bug address and inside flag
  logic          bug_inside;
  logic [AW-1:0] bug_addr;

  assign bug_inside = !bug_col_q[CBW-1];
  assign bug_addr   = AW'(AW'(bug_row_q) * WidthA) + AW'(bug_col_q[CUW-1:0]);

  // image store: pixel writes, sweep reads and step reads
  assign img_we    = cmd_i.accept && (op_i == OP_WRITE) && in_inside;
  assign img_wdata = (pixel_value_i == FG_BYTE);
  assign img_raddr = cmd_i.step_rd ? bug_addr : scan_addr_q;

  bct_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (in_addr),
    .wdata_i (img_wdata),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  // step evaluation
  logic                  fg;
  head_e                 head_turn, head_nxt;
  logic [RBW-1:0]        row_nxt;
  logic signed [CBW-1:0] col_nxt;
  logic [STEP_W-1:0]     steps_nxt, limit_eff;

  assign fg = bug_in_q && img_rdata;

  always_comb begin
    if (fg) begin
      head_turn = head_e'(head_q + (mode_q ? 2'd2 : 2'd3));
    end else begin
      head_turn = head_e'(head_q + 2'd1);
    end
    row_nxt  = bug_row_q;
    col_nxt  = bug_col_q;
    head_nxt = head_turn;
    case (head_turn)
      HEAD_W: begin
        if (bug_col_q > $signed(CBW'(0))) col_nxt = bug_col_q - CBW'(1);
        else head_nxt = head_e'(head_turn + 2'd3);
      end
      HEAD_E: begin
        if (bug_col_q < ColLastS) col_nxt = bug_col_q + CBW'(1);
        else head_nxt = head_e'(head_turn + 2'd1);
      end
      HEAD_N: begin
        if (bug_row_q != '0) row_nxt = bug_row_q - RBW'(1);
        else head_nxt = head_e'(head_turn + 2'd1);
      end
      default: begin
        if (bug_row_q < RowLast) row_nxt = bug_row_q + RBW'(1);
        else head_nxt = head_e'(head_turn + 2'd1);
      end
    endcase
  end

  assign steps_nxt = steps_q + STEP_W'(1);
  assign limit_eff = (limit_q == '0) ? STEP_W'(1) : limit_q;

  // track store: cleared by the sweep, marked by steps
  assign trk_we    = cmd_i.scan_run || (cmd_i.step_ev && fg);
  assign trk_wdata = !cmd_i.scan_run;
  assign trk_waddr = cmd_i.scan_run ? scan_addr_q : bug_addr_q;

  bct_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_trk_ram (
    .clk_i   (clk_i),
    .we_i    (trk_we),
    .waddr_i (trk_waddr),
    .wdata_i (trk_wdata),
    .raddr_i (in_addr),
    .rdata_o (trk_rdata)
  );

  // sweep and search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q  <= '0;
      scan_col_q  <= '0;
      scan_addr_q <= '0;
      scan_vld_q  <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      scan_vld_q <= cmd_i.scan_run;
      if (cmd_i.scan_init) begin
        scan_row_q  <= '0;
        scan_col_q  <= '0;
        scan_addr_q <= '0;
        found_q     <= 1'b0;
      end else begin
        if (cmd_i.scan_run) begin
          scan_addr_q <= scan_addr_q + AW'(1);
          if (scan_col_q == ColLast) begin
            scan_col_q <= '0;
            scan_row_q <= scan_row_q + RBW'(1);
          end else begin
            scan_col_q <= scan_col_q + CUW'(1);
          end
        end
        if (scan_vld_q && img_rdata && !found_q) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // sweep position of the data coming back; start is one column left of the first hit
  always_ff @(posedge clk_i) begin
    scan_row_dly_q <= scan_row_q;
    scan_col_dly_q <= scan_col_q;
    if (scan_vld_q && img_rdata && !found_q) begin
      row0_q <= scan_row_dly_q;
      col0_q <= $signed({1'b0, scan_col_dly_q}) - CBW'(1);
    end
  end

  // bug position, heading and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bug_row_q  <= '0;
      bug_col_q  <= '0;
      head_q     <= HEAD_N;
      steps_q    <= '0;
      track_ok_q <= 1'b0;
    end else begin
      if (cmd_i.scan_init) begin
        steps_q    <= '0;
        track_ok_q <= 1'b1;
      end else if (cmd_i.bug_init) begin
        bug_row_q <= row0_q;
        bug_col_q <= col0_q;
        head_q    <= HEAD_N;
      end else if (cmd_i.step_ev) begin
        bug_row_q <= row_nxt;
        bug_col_q <= col_nxt;
        head_q    <= head_nxt;
        steps_q   <= steps_nxt;
      end
    end
  end

  // address and inside flag of the pixel under evaluation
  always_ff @(posedge clk_i) begin
    if (cmd_i.step_rd) begin
      bug_addr_q <= bug_addr;
      bug_in_q   <= bug_inside;
    end
  end

  // result of pixel writes, track reads and unused ops, in the cycle after the transfer
  logic pend_q, pend_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      pend_rd_q <= 1'b0;
    end else begin
      pend_q    <= cmd_i.accept && (op_i != OP_TRACE);
      pend_rd_q <= cmd_i.accept && (op_i == OP_READ) && in_inside && track_ok_q;
    end
  end

  assign out_vld_o    = pend_q;
  assign track_bit_o  = pend_rd_q && trk_rdata;
  assign step_count_o = steps_q;

  // status to controller
  assign stat_o.scan_last = (scan_row_q == RowLast) && (scan_col_q == ColLast);
  assign stat_o.found     = found_q;
  assign stat_o.at_start  = (row_nxt == row0_q) && (col_nxt == col0_q) && (head_nxt == HEAD_N);
  assign stat_o.at_limit  = (steps_nxt >= limit_eff);

endmodule

>>> hdl/binary_contour_bug_tracer.sv
// Pixel write, track read and unused op: result strobe in the cycle after the transfer,
// one transfer per cycle while no trace runs.
// Trace: a sweep clearing the track store and searching the image, tail and setup
// states, bug steps (registered image read, then turn and move), and the result
// strobe in the cycle after the last step; busy is high for the whole run.
// Reset is asynchronous: track reads give 0 until the first trace, image is undefined.
// ----------------------------------------------------------------------------
// binary_contour_bug_tracer
// Square-tracing contour follower (trace mode 0) over a binary image with a track store.
// ----------------------------------------------------------------------------
module binary_contour_bug_tracer import bct_pkg::*; #(
  parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT = DEF_IMG_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      op_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [PIX_W-1:0]     pixel_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 track_bit_o,
  output logic [STEP_W-1:0]    step_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     trace_done, dp_vld;

  // controller
  bct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .op_i     (op_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (trace_done),
    .status_o (status_o)
  );

  // datapath
  bct_datapath #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .pixel_value_i (pixel_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_vld_o     (dp_vld),
    .track_bit_o   (track_bit_o),
    .step_count_o  (step_count_o)
  );

  // trace results and short-op results never share a cycle
  assign done_o = trace_done || dp_vld;

endmodule

>>> hdl/bct_checker.sv
// ----------------------------------------------------------------------------
// bct_checker
// Port-level checks of the tracer, bound to the top level.
// ----------------------------------------------------------------------------
module bct_checker import bct_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic [OP_W-1:0]     op_i,
  input logic                done_o,
  input logic [STATUS_W-1:0] status_o,
  input logic                track_bit_o,
  input logic [STEP_W-1:0]   step_count_o
);

  // a short op transfer gives its result in the next cycle
  a_short_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i != OP_TRACE)) |=> done_o)
    else $error("short op transfer without result strobe");

  // a trace transfer holds off further input
  a_trace_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_TRACE)) |=> (busy && !done_o))
    else $error("trace transfer did not raise busy");

  // a trace ends with its result strobe
  a_trace_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(done_o))
    else $error("busy dropped without trace result");

  // an empty image reports no steps
  a_empty_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_o == ST_EMPTY) |-> (done_o && (step_count_o == '0) && !track_bit_o))
    else $error("empty image result with steps or track bit");

endmodule

bind binary_contour_bug_tracer bct_checker u_bct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .op_i         (op_i),
  .done_o       (done_o),
  .status_o     (status_o),
  .track_bit_o  (track_bit_o),
  .step_count_o (step_count_o)
);
